// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the RTL; they drop out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted (reset is active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property checked at every edge, including during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/kdmh_pkg.sv
// ----------------------------------------------------------------------------
// kdmh_pkg
// Types and constants of the multi-key debouncer with hold levels.
// ----------------------------------------------------------------------------
package kdmh_pkg;

  localparam int NUM_KEYS    = 3;
  localparam int COUNT_WIDTH = 16;
  localparam int CONTACTS    = 4;
  localparam int TICK_W      = 16;
  localparam int KEY_IDX_W   = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CMP_W       = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_HOLD1   = 3'd2,
    EV_HOLD2   = 3'd3,
    EV_HOLD3   = 3'd4,
    EV_RELEASE = 3'd5
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE    = 3'd0,
    CFG_HOLD1       = 3'd1,
    CFG_HOLD2       = 3'd2,
    CFG_HOLD3       = 3'd3,
    CFG_HOLD_LEVELS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] key_index;
    logic [3:0]           key_contacts;
    logic                 error_active;
    logic                 power_on;
  } kdmh_in_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       key_enabled;
    logic       key_confirmed;
  } kdmh_out_t;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] hold1_ticks;
    logic [TICK_W-1:0] hold2_ticks;
    logic [TICK_W-1:0] hold3_ticks;
    logic [1:0]        hold_levels;
  } kdmh_cfg_t;

  typedef struct packed {
    logic                        enabled;
    logic                        err_latch;
    logic                        touch;
    logic                        confirmed;
    logic [2:0]                  hold_flags;
    logic [COUNT_WIDTH-1:0]      deb_cnt;
    logic [2:0][COUNT_WIDTH-1:0] hold_cnt;
  } key_state_t;

endpackage

// File: src/kdmh_cfg.sv
// ----------------------------------------------------------------------------
// kdmh_cfg
// Configuration register file: tick thresholds and number of hold levels.
// ----------------------------------------------------------------------------
module kdmh_cfg
  import kdmh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CFG_IDX_W-1:0] wr_index_i,
  input  logic [TICK_W-1:0]    wr_data_i,
  output kdmh_cfg_t            cfg_o
);

  kdmh_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_reg_e'(wr_index_i))
        CFG_DEBOUNCE:    cfg_d.debounce_ticks = wr_data_i;
        CFG_HOLD1:       cfg_d.hold1_ticks    = wr_data_i;
        CFG_HOLD2:       cfg_d.hold2_ticks    = wr_data_i;
        CFG_HOLD3:       cfg_d.hold3_ticks    = wr_data_i;
        CFG_HOLD_LEVELS: cfg_d.hold_levels    = wr_data_i[1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= TICK_W'(5);
      cfg_q.hold1_ticks    <= TICK_W'(100);
      cfg_q.hold2_ticks    <= TICK_W'(300);
      cfg_q.hold3_ticks    <= TICK_W'(500);
      cfg_q.hold_levels    <= 2'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/kdmh_step.sv
// ----------------------------------------------------------------------------
// kdmh_step
// Next-state and event logic for one tick of one key.
// ----------------------------------------------------------------------------
module kdmh_step
  import kdmh_pkg::*;
(
  input  kdmh_cfg_t  cfg_i,
  input  key_state_t key_i,
  input  kdmh_in_t   tick_i,
  output key_state_t key_o,
  output event_e     event_o
);

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
  endfunction

  function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
                                   input logic [TICK_W-1:0]      thr);
    return CMP_W'(c) >= CMP_W'(thr);
  endfunction

  logic [COUNT_WIDTH-1:0] deb_inc;
  logic [COUNT_WIDTH-1:0] h0_inc, h1_inc, h2_inc;
  logic                   lvl2_on, lvl3_on;

  assign deb_inc = bump(key_i.deb_cnt);
  assign h0_inc  = bump(key_i.hold_cnt[0]);
  assign h1_inc  = bump(key_i.hold_cnt[1]);
  assign h2_inc  = bump(key_i.hold_cnt[2]);
  // A level setting of zero behaves as one level.
  assign lvl2_on = cfg_i.hold_levels >= 2'd2;
  assign lvl3_on = cfg_i.hold_levels == 2'd3;

  always_comb begin
    key_o   = key_i;
    event_o = EV_NONE;
    if (!key_i.enabled) begin
      if (tick_i.power_on) begin
        key_o.enabled = 1'b1;
      end
    end else begin
      if (!tick_i.error_active) begin
        key_o.err_latch = 1'b0;
        key_o.touch     = |tick_i.key_contacts[CONTACTS-1:0];
      end else if (!key_i.err_latch) begin
        // First errored tick forces a confirmed state so a release follows.
        key_o.err_latch = 1'b1;
        key_o.touch     = 1'b0;
        key_o.confirmed = 1'b1;
      end

      if (key_o.touch) begin
        if (!key_o.confirmed) begin
          key_o.deb_cnt = deb_inc;
          if (reached(deb_inc, cfg_i.debounce_ticks)) begin
            key_o.deb_cnt   = '0;
            key_o.confirmed = 1'b1;
            event_o         = EV_PRESS;
          end
        end else if (!key_i.hold_flags[0]) begin
          key_o.hold_cnt[0] = h0_inc;
          if (reached(h0_inc, cfg_i.hold1_ticks)) begin
            key_o.hold_cnt[0]    = '0;
            key_o.hold_flags[0]  = 1'b1;
            event_o              = EV_HOLD1;
          end
        end else if (lvl2_on) begin
          if (!key_i.hold_flags[1]) begin
            key_o.hold_cnt[1] = h1_inc;
            if (reached(h1_inc, cfg_i.hold2_ticks)) begin
              key_o.hold_cnt[1]   = '0;
              key_o.hold_flags[1] = 1'b1;
              event_o             = EV_HOLD2;
            end
          end else if (lvl3_on && !key_i.hold_flags[2]) begin
            key_o.hold_cnt[2] = h2_inc;
            if (reached(h2_inc, cfg_i.hold3_ticks)) begin
              key_o.hold_cnt[2]   = '0;
              key_o.hold_flags[2] = 1'b1;
              event_o             = EV_HOLD3;
            end
          end
        end
      end else if (key_o.confirmed) begin
        key_o.deb_cnt = deb_inc;
        if (reached(deb_inc, cfg_i.debounce_ticks)) begin
          key_o.deb_cnt    = '0;
          key_o.confirmed  = 1'b0;
          key_o.hold_flags = '0;
          key_o.hold_cnt   = '0;
          event_o          = EV_RELEASE;
        end
      end
    end
  end

endmodule

// File: src/key_debounce_multi_hold.sv
// ----------------------------------------------------------------------------
// key_debounce_multi_hold
// Per-key push-button debouncer with press, three hold levels and release.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one tick for the key named by key_index. It carries
//   the raw contact bits, the system error flag and the power-on flag.
//   Every input word yields exactly one output word with the event code
//   (none, press, hold1..3, release) and the key's enabled and debounced
//   state after that tick. An out-of-range key index gives an all-zero word.
//   A word passes from the input register, through the per-key state
//   update, into the output register. One word is taken per cycle while
//   the receiver keeps up, also for runs of ticks on one key, since each
//   key's state is read, updated and written back as the word leaves the
//   input register. When the receiver stalls, the output register holds its
//   word and the input register takes one more word before in_ready_o drops.
//   Configuration writes are always ready and take effect on the next cycle;
//   the user must make them while no word is in flight, as the block does
//   not enforce this. Reset clears all key state and both stages and loads
//   the default thresholds (debounce 5, hold 100/300/500, three levels).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_debounce_multi_hold
  import kdmh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kdmh_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kdmh_out_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i
);

  kdmh_cfg_t  cfg;
  key_state_t key_q [NUM_KEYS];
  key_state_t cur_key, nxt_key;
  event_e     step_event;

  logic       s1_valid_q;
  kdmh_in_t   s1_data_q;
  logic       out_valid_q;
  kdmh_out_t  out_data_q, out_data_d;
  logic       s1_fire, in_fire, key_in_range;

  assign cfg_ready_o = 1'b1;

  kdmh_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign key_in_range = 32'(s1_data_q.key_index) < NUM_KEYS;

  always_comb begin
    cur_key = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (32'(s1_data_q.key_index) == k) begin
        cur_key = key_q[k];
      end
    end
  end

  kdmh_step u_step (
    .cfg_i   (cfg),
    .key_i   (cur_key),
    .tick_i  (s1_data_q),
    .key_o   (nxt_key),
    .event_o (step_event)
  );

  always_comb begin
    out_data_d = '0;
    if (key_in_range) begin
      out_data_d.event_code    = step_event;
      out_data_d.key_enabled   = nxt_key.enabled;
      out_data_d.key_confirmed = nxt_key.confirmed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (s1_fire) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_q[k] <= '0;
      end
    end else if (s1_fire) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (32'(s1_data_q.key_index) == k) begin
          key_q[k] <= nxt_key;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A word leaving the input register always lands in the output register.
  `ASSERT_CLK(a_fire_fills_out, clk_i, rst_ni, s1_fire |=> out_valid_q, "s1 word lost")
  // Events are only reported for keys that are already enabled.
  `ASSERT_CLK(a_event_enabled, clk_i, rst_ni,
    out_valid_q && (out_data_q.event_code != EV_NONE) |-> out_data_q.key_enabled,
    "event on a disabled key")

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key_chk
    // Hold levels only exist while the key is confirmed pressed.
    `ASSERT_ALWAYS(a_hold_needs_conf, clk_i,
      (key_q[g].hold_flags != 3'b000) |-> key_q[g].confirmed,
      "hold flag set without confirmed press")
    // A disabled key never carries a confirmed state.
    `ASSERT_ALWAYS(a_conf_needs_en, clk_i,
      key_q[g].confirmed |-> key_q[g].enabled, "confirmed key not enabled")
  end

endmodule

// File: tb/key_debounce_multi_hold_tb.sv
// ----------------------------------------------------------------------------
// key_debounce_multi_hold_tb
// Self-checking bench for the multi-key debouncer with hold levels. It keeps
// its own per-key model of debounce, hold and release, predicts the event
// word for every accepted tick and compares it in order with the block's
// output words, under several threshold settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_debounce_multi_hold_tb;
  import kdmh_pkg::*;

  localparam int RUN_LIMIT_NS = 10_000_000;
  localparam int MAX_PRINTS   = 40;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  kdmh_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  kdmh_out_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TICK_W-1:0]    cfg_data_i  = '0;

  key_debounce_multi_hold dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Model state and bookkeeping.
  key_state_t key_model [NUM_KEYS];
  kdmh_cfg_t  cfg_model;
  kdmh_out_t  pending_events[$];
  bit         held [NUM_KEYS];
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         mismatches     = 0;
  int         ticks_sent     = 0;
  int         words_checked  = 0;
  int         event_seen [8];

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Advances the model of the addressed key by one tick and returns the word
  // the block should produce for it.
  function automatic kdmh_out_t next_key_event(input kdmh_in_t t);
    key_state_t        s;
    kdmh_out_t         r;
    event_e            ev;
    int                lv;
    bit                pressed;
    logic [TICK_W-1:0] lim [3];
    r  = '0;
    ev = EV_NONE;
    if (t.key_index >= NUM_KEYS) return r;
    s       = key_model[t.key_index];
    pressed = |t.key_contacts[CONTACTS-1:0];
    lv      = (cfg_model.hold_levels == 2'd0) ? 1 : int'(cfg_model.hold_levels);
    lim[0]  = cfg_model.hold1_ticks;
    lim[1]  = cfg_model.hold2_ticks;
    lim[2]  = cfg_model.hold3_ticks;
    if (!s.enabled) begin
      if (t.power_on) s.enabled = 1'b1;
    end else begin
      if (!t.error_active) begin
        s.err_latch = 1'b0;
        s.touch     = pressed;
      end else if (!s.err_latch) begin
        // The first errored tick forces a confirmed state so that a release
        // debounce follows.
        s.err_latch = 1'b1;
        s.touch     = 1'b0;
        s.confirmed = 1'b1;
      end
      if (s.touch) begin
        if (!s.confirmed) begin
          s.deb_cnt = sat_inc(s.deb_cnt);
          if (s.deb_cnt >= cfg_model.debounce_ticks) begin
            s.deb_cnt   = '0;
            s.confirmed = 1'b1;
            ev          = EV_PRESS;
          end
        end else begin
          // Only the lowest level not yet reached counts, and only if it is
          // among the levels in use.
          for (int j = 0; j < 3; j++) begin
            if (!s.hold_flags[j]) begin
              if (j < lv) begin
                s.hold_cnt[j] = sat_inc(s.hold_cnt[j]);
                if (s.hold_cnt[j] >= lim[j]) begin
                  s.hold_cnt[j]   = '0;
                  s.hold_flags[j] = 1'b1;
                  ev              = event_e'(EV_HOLD1 + j);
                end
              end
              break;
            end
          end
        end
      end else if (s.confirmed) begin
        s.deb_cnt = sat_inc(s.deb_cnt);
        if (s.deb_cnt >= cfg_model.debounce_ticks) begin
          s.deb_cnt    = '0;
          s.confirmed  = 1'b0;
          s.hold_flags = '0;
          s.hold_cnt   = '0;
          ev           = EV_RELEASE;
        end
      end
    end
    key_model[t.key_index] = s;
    r.event_code    = ev;
    r.key_enabled   = s.enabled;
    r.key_confirmed = s.confirmed;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Every accepted tick queues its predicted word.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_events.push_back(next_key_event(in_data_i));
      ticks_sent++;
    end
  end

  // Every accepted output word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    kdmh_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (out_data_o.event_code <= EV_RELEASE) event_seen[out_data_o.event_code]++;
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected word", int'(out_data_o), 0);
      end else begin
        want = pending_events.pop_front();
        if (out_data_o.event_code !== want.event_code)
          report_mismatch("event_code", int'(out_data_o.event_code),
                          int'(want.event_code));
        if (out_data_o.key_enabled !== want.key_enabled)
          report_mismatch("key_enabled", int'(out_data_o.key_enabled),
                          int'(want.key_enabled));
        if (out_data_o.key_confirmed !== want.key_confirmed)
          report_mismatch("key_confirmed", int'(out_data_o.key_confirmed),
                          int'(want.key_confirmed));
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic kdmh_in_t tick(input int k, input logic [3:0] c, input bit err,
                                    input bit pwr);
    kdmh_in_t t;
    t.key_index    = k[KEY_IDX_W-1:0];
    t.key_contacts = c;
    t.error_active = err;
    t.power_on     = pwr;
    return t;
  endfunction

  // Called and returning at a falling edge; valid stays high after the
  // handshake so that back-to-back words run without a gap in valid.
  task automatic send_tick(input kdmh_in_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all five registers in one burst while nothing is in flight.
  task automatic set_config(input kdmh_cfg_t c);
    cfg_reg_e          r;
    logic [TICK_W-1:0] v;
    wait_idle();
    for (int i = 0; i <= int'(CFG_HOLD_LEVELS); i++) begin
      r = cfg_reg_e'(i);
      case (r)
        CFG_DEBOUNCE: v = c.debounce_ticks;
        CFG_HOLD1:    v = c.hold1_ticks;
        CFG_HOLD2:    v = c.hold2_ticks;
        CFG_HOLD3:    v = c.hold3_ticks;
        default:      v = {{(TICK_W-2){1'b0}}, c.hold_levels};
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= v;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (r)
        CFG_DEBOUNCE: cfg_model.debounce_ticks = v;
        CFG_HOLD1:    cfg_model.hold1_ticks    = v;
        CFG_HOLD2:    cfg_model.hold2_ticks    = v;
        CFG_HOLD3:    cfg_model.hold3_ticks    = v;
        default:      cfg_model.hold_levels    = v[1:0];
      endcase
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic kdmh_cfg_t thresholds(input int deb, input int h1, input int h2,
                                           input int h3, input int lv);
    kdmh_cfg_t c;
    c.debounce_ticks = deb[TICK_W-1:0];
    c.hold1_ticks    = h1[TICK_W-1:0];
    c.hold2_ticks    = h2[TICK_W-1:0];
    c.hold3_ticks    = h3[TICK_W-1:0];
    c.hold_levels    = lv[1:0];
    return c;
  endfunction

  // Keys stay inert until a tick sees power; an out-of-range index gives zeros.
  task automatic test_power_gating();
    send_tick(tick(0, 4'hF, 1'b0, 1'b0));
    send_tick(tick(0, 4'hF, 1'b0, 1'b1));
    send_tick(tick(3, 4'hF, 1'b1, 1'b1));
    send_tick(tick(1, 4'h0, 1'b0, 1'b1));
    send_tick(tick(2, 4'h0, 1'b0, 1'b1));
  endtask

  // Reset thresholds: five pressed ticks confirm the press.
  task automatic test_default_press();
    send_tick(tick(0, 4'h1, 1'b0, 1'b1));
    send_tick(tick(0, 4'h2, 1'b0, 1'b0));
    send_tick(tick(0, 4'h4, 1'b0, 1'b1));
    send_tick(tick(0, 4'h8, 1'b0, 1'b1));
    send_tick(tick(0, 4'hF, 1'b0, 1'b1));
  endtask

  // All three hold levels in turn, then a bouncy release; the release count
  // survives the bounce.
  task automatic test_hold_and_release();
    set_config(thresholds(2, 1, 1, 1, 3));
    repeat (4) send_tick(tick(0, 4'h5, 1'b0, 1'b1));
    send_tick(tick(0, 4'h0, 1'b0, 1'b1));
    send_tick(tick(0, 4'hA, 1'b0, 1'b1));
    send_tick(tick(0, 4'h0, 1'b0, 1'b1));
  endtask

  // An active error forces a confirmed state that then debounces to release.
  task automatic test_error_release();
    send_tick(tick(1, 4'h3, 1'b1, 1'b1));
    send_tick(tick(1, 4'h3, 1'b1, 1'b1));
    send_tick(tick(1, 4'h3, 1'b0, 1'b1));
    send_tick(tick(1, 4'h3, 1'b0, 1'b1));
  endtask

  // A threshold lowered below the running count fires on the next tick; a
  // level count of zero acts as one level.
  task automatic test_threshold_lowering();
    set_config(thresholds(1, 10, 10, 10, 3));
    repeat (5) send_tick(tick(2, 4'h7, 1'b0, 1'b1));
    set_config(thresholds(1, 2, 10, 10, 3));
    send_tick(tick(2, 4'h7, 1'b0, 1'b1));
    set_config(thresholds(1, 2, 1, 1, 0));
    send_tick(tick(2, 4'h7, 1'b0, 1'b1));
  endtask

  // Largest thresholds: a short run of held ticks raises no hold event.
  task automatic test_max_threshold();
    set_config(thresholds(1, 65535, 65535, 65535, 1));
    repeat (20) send_tick(tick(1, 4'h9, 1'b0, 1'b1));
  endtask

  // Well-formed press and release runs on random keys, with bounces, errors,
  // power drops and out-of-range indexes mixed in.
  task automatic random_ticks(input int n);
    int       k;
    kdmh_in_t t;
    repeat (n) begin
      k = ($urandom_range(99) < 5) ? 3 : $urandom_range(NUM_KEYS - 1);
      if (k < NUM_KEYS && $urandom_range(99) < 8) held[k] = !held[k];
      t.key_index    = k[KEY_IDX_W-1:0];
      t.key_contacts = (k < NUM_KEYS && held[k]) ? 4'($urandom_range(15, 1)) : 4'h0;
      if ($urandom_range(99) < 6) t.key_contacts = 4'($urandom_range(15));
      t.error_active = ($urandom_range(99) < 3);
      t.power_on     = ($urandom_range(99) < 92);
      send_tick(t);
    end
  endtask

  task automatic test_random_traffic();
    int idle_pct  [4] = '{0, 54, 0, 30};
    int stall_pct [4] = '{0, 0, 54, 30};
    kdmh_cfg_t cfgs [4];
    cfgs[0] = thresholds(1, 1, 2, 3, 3);
    cfgs[1] = thresholds(3, 4, 2, 5, 2);
    cfgs[2] = thresholds(0, 0, 0, 0, 0);
    cfgs[3] = thresholds(2, 3, 3, 3, 1);
    for (int p = 0; p < 4; p++) begin
      set_config(cfgs[p]);
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      random_ticks(450);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    cfg_model = thresholds(5, 100, 300, 500, 3);
    foreach (key_model[k]) key_model[k] = '0;
    foreach (held[k]) held[k] = 1'b0;
    foreach (event_seen[i]) event_seen[i] = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_power_gating();
    test_default_press();
    test_hold_and_release();
    test_error_release();
    test_threshold_lowering();
    test_max_threshold();
    test_random_traffic();

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d ticks and %0d checked words over several threshold settings.",
             ticks_sent, words_checked);
    $display("Events seen: %0d press, %0d hold1, %0d hold2, %0d hold3, %0d release.",
             event_seen[EV_PRESS], event_seen[EV_HOLD1], event_seen[EV_HOLD2],
             event_seen[EV_HOLD3], event_seen[EV_RELEASE]);
    if (mismatches == 0) begin
      $display("key_debounce_multi_hold_tb: done, clean");
    end else begin
      $display("key_debounce_multi_hold_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d words outstanding.", pending_events.size());
    $display("key_debounce_multi_hold_tb: done, errors");
    $finish;
  end

endmodule
